/* design/lrc_pkg.sv */
// Package with shared types and constants of the LRU resource cache.
package lrc_pkg;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned HANDLE_BITS_DEF = 32;
  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam int unsigned FUNC_BITS = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_GET     = 2'd0,
    FUNC_PUT     = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_e;
endpackage

/* design/lrc_if.sv */
// Valid/ready channel interfaces for the cache request and response.
interface lrc_req_if #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HANDLE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [KEY_BITS-1:0]    key;
  logic [HANDLE_BITS-1:0] handle;
  modport source (output valid, func, key, handle, input ready);
  modport sink (input valid, func, key, handle, output ready);
endinterface

interface lrc_rsp_if #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HANDLE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [31:0]            handle_out;
  logic                   evicted;
  logic [31:0]            evicted_key;
  logic [4:0]             entry_count;
  modport source (output valid, hit, handle_out, evicted, evicted_key, entry_count,
                  input ready);
  modport sink (input valid, hit, handle_out, evicted, evicted_key, entry_count,
                output ready);
endinterface

/* design/lru_resource_cache.sv */
// Top level of the LRU resource cache.
// A request passes through the front-end queue, a lookup state, for a put with a
// non-null handle an eviction state that drops one entry at a time until the count
// fits, and an execute state that registers the result. The back-end sequencer
// finishes one request before it takes another; the two-entry front queue can accept more meanwhile.
// Reset clears all entries, the count and the queue; capacity resets to 16.
module lru_resource_cache #(
  parameter int unsigned DEPTH = lrc_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = lrc_pkg::KEY_BITS_DEF,
  parameter int unsigned HANDLE_BITS = lrc_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  lrc_req_if.sink     req,
  lrc_rsp_if.source   rsp
);
  import lrc_pkg::*;

  logic [CAP_BITS-1:0]    cap_q;
  logic                   q_valid, q_pop;
  logic [1:0]             q_func;
  logic [KEY_BITS-1:0]    q_key;
  logic [HANDLE_BITS-1:0] q_handle;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CAP_RESET;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  lrc_front #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_func_i(req.func),
    .in_key_i(req.key), .in_handle_i(req.handle),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_func_o(q_func),
    .q_key_o(q_key), .q_handle_o(q_handle)
  );

  lrc_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk_i, .rst_ni, .cap_i(cap_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_func_i(q_func),
    .q_key_i(q_key), .q_handle_i(q_handle),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .hit_o(rsp.hit),
    .handle_out_o(rsp.handle_out), .evicted_o(rsp.evicted),
    .evicted_key_o(rsp.evicted_key), .entry_count_o(rsp.entry_count)
  );
endmodule

/* design/lrc_front.sv */
// Front end: accepts requests into a two-entry queue toward the back end.
module lrc_front #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_func_i,
  input  logic [KEY_BITS-1:0]    in_key_i,
  input  logic [HANDLE_BITS-1:0] in_handle_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output logic [1:0]             q_func_o,
  output logic [KEY_BITS-1:0]    q_key_o,
  output logic [HANDLE_BITS-1:0] q_handle_o
);
  import lrc_pkg::*;

  localparam int unsigned W = 2 + KEY_BITS + HANDLE_BITS;

  logic [W-1:0] slot_q [2];
  logic [1:0]   cnt_q, cnt_d;
  logic         rd_q, wr_q;
  logic         push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign {q_func_o, q_key_o, q_handle_o} = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= {in_func_i, in_key_i, in_handle_i};
  end
endmodule

/* design/lrc_back.sv */
// Back end: tag lookup, recency update, eviction and result register.
module lrc_back #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [4:0]             cap_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic [1:0]             q_func_i,
  input  logic [KEY_BITS-1:0]    q_key_i,
  input  logic [HANDLE_BITS-1:0] q_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic [31:0]            handle_out_o,
  output logic                   evicted_o,
  output logic [31:0]            evicted_key_o,
  output logic [4:0]             entry_count_o
);
  import lrc_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {ST_LOOK, ST_EXEC, ST_EVICT} state_e;

  logic [KEY_BITS-1:0]    key_q [DEPTH];
  logic [HANDLE_BITS-1:0] hdl_q [DEPTH];
  logic [IW-1:0]          rank_q [DEPTH];
  logic [DEPTH-1:0]       valid_q, live_q;
  logic [CW-1:0]          held_q;
  state_e                 state_q;

  logic                   found_q;
  logic [IW-1:0]          slot_q;
  logic                   ev_q;
  logic [31:0]            evk_q;
  logic                   out_valid_q, hit_q, evicted_q;
  logic [31:0]            hout_q, evko_q;
  logic [4:0]             cnt_out_q;

  // Effective capacity clamped to 1..DEPTH.
  logic [CW:0] cap_eff;
  always_comb begin
    if (cap_i == 5'd0) cap_eff = (CW+1)'(1);
    else if ({{(CW+1){1'b0}}, cap_i} > (CW+6)'(DEPTH)) cap_eff = (CW+1)'(DEPTH);
    else cap_eff = (CW+1)'(cap_i);
  end

  // Parallel tag match.
  logic          m_found;
  logic [IW-1:0] m_slot;
  always_comb begin
    m_found = 1'b0;
    m_slot  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == q_key_i) begin
        m_found = 1'b1;
        m_slot  = IW'(i);
      end
    end
  end

  // Oldest slot (rank equal to held-1) and first free slot.
  logic [IW-1:0] old_slot, free_slot;
  logic          old_found;
  always_comb begin
    old_slot  = '0;
    old_found = 1'b0;
    free_slot = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid_q[i] && (CW'(rank_q[i]) == held_q - CW'(1))) begin
        old_slot  = IW'(i);
        old_found = 1'b1;
      end
      if (!valid_q[i]) free_slot = IW'(i);
    end
  end

  wire out_free = !out_valid_q || out_ready_i;
  // Eviction needed before a put finishes.
  wire [CW:0] lim = found_q ? cap_eff : cap_eff - (CW+1)'(1);
  wire need_ev = ({1'b0, held_q} > lim) && old_found;
  // Result classification in the execute state.
  wire get_hit = (q_func_i == FUNC_GET) && found_q && live_q[slot_q];
  wire put_new = (q_handle_i != '0) && !found_q && (held_q < CW'(DEPTH));

  assign q_pop_o = q_valid_i && (state_q == ST_EXEC) && out_free;

  // Sequencer and state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOOK;
      valid_q     <= '0;
      live_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      ev_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !q_pop_o) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_LOOK: begin
          if (q_valid_i) begin
            found_q <= m_found;
            slot_q  <= m_slot;
            ev_q    <= 1'b0;
            evk_q   <= '0;
            state_q <= (q_func_i == FUNC_PUT && q_handle_i != '0) ? ST_EVICT : ST_EXEC;
            // A put on a held key makes it most recent before any eviction.
            if (q_func_i == FUNC_PUT && q_handle_i != '0 && m_found) begin
              hdl_q[m_slot]  <= q_handle_i;
              live_q[m_slot] <= 1'b1;
              for (int i = 0; i < DEPTH; i++)
                if (valid_q[i] && rank_q[i] < rank_q[m_slot]) rank_q[i] <= rank_q[i] + 1'b1;
              rank_q[m_slot] <= '0;
            end
          end
        end
        ST_EVICT: begin
          // One eviction per cycle until the count fits, then fall to execute.
          if (need_ev) begin
            if (!ev_q) begin
              ev_q  <= 1'b1;
              evk_q <= 32'(key_q[old_slot]);
            end
            valid_q[old_slot] <= 1'b0;
            live_q[old_slot]  <= 1'b0;
            held_q <= held_q - CW'(1);
            if (found_q && old_slot == slot_q) found_q <= 1'b0;
          end else begin
            state_q <= ST_EXEC;
          end
        end
        default: begin
          if (q_pop_o) begin
            out_valid_q <= 1'b1;
            hit_q       <= get_hit;
            hout_q      <= get_hit ? 32'(hdl_q[slot_q]) : 32'd0;
            evicted_q   <= ev_q;
            evko_q      <= evk_q;
            state_q     <= ST_LOOK;
            unique case (q_func_i)
              FUNC_GET: begin
                if (found_q) begin
                  if (live_q[slot_q]) begin
                    for (int i = 0; i < DEPTH; i++)
                      if (valid_q[i] && rank_q[i] < rank_q[slot_q]) rank_q[i] <= rank_q[i] + 1'b1;
                    rank_q[slot_q] <= '0;
                  end else begin
                    valid_q[slot_q] <= 1'b0;
                    live_q[slot_q]  <= 1'b0;
                    for (int i = 0; i < DEPTH; i++)
                      if (valid_q[i] && rank_q[i] > rank_q[slot_q]) rank_q[i] <= rank_q[i] - 1'b1;
                    held_q <= held_q - CW'(1);
                  end
                end
                cnt_out_q <= 5'(found_q && !live_q[slot_q] ? held_q - CW'(1) : held_q);
              end
              FUNC_PUT: begin
                if (q_handle_i != '0) begin
                  if (found_q) begin
                    hdl_q[slot_q]  <= q_handle_i;
                    live_q[slot_q] <= 1'b1;
                    for (int i = 0; i < DEPTH; i++)
                      if (valid_q[i] && rank_q[i] < rank_q[slot_q]) rank_q[i] <= rank_q[i] + 1'b1;
                    rank_q[slot_q] <= '0;
                  end else if (put_new) begin
                    for (int i = 0; i < DEPTH; i++)
                      if (valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
                    valid_q[free_slot] <= 1'b1;
                    live_q[free_slot]  <= 1'b1;
                    key_q[free_slot]   <= q_key_i;
                    hdl_q[free_slot]   <= q_handle_i;
                    rank_q[free_slot]  <= '0;
                    held_q    <= held_q + CW'(1);
                  end
                end
                cnt_out_q <= 5'(put_new ? held_q + CW'(1) : held_q);
              end
              FUNC_CLEAR: begin
                valid_q   <= '0;
                live_q    <= '0;
                held_q    <= '0;
                cnt_out_q <= '0;
              end
              default: begin
                if (found_q) live_q[slot_q] <= 1'b0;
                cnt_out_q <= 5'(held_q);
              end
            endcase
          end
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign handle_out_o  = hout_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evko_q;
  assign entry_count_o = cnt_out_q;
endmodule

/* design/lrc_checker.sv */
// Port-level checker for the LRU resource cache, bound to the top level.
module lrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_hit,
  input logic [31:0] rsp_handle_out,
  input logic        rsp_evicted,
  input logic [31:0] rsp_evicted_key,
  input logic [4:0]  rsp_entry_count
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_handle_out) && $stable(rsp_evicted) && $stable(rsp_evicted_key) &&
      $stable(rsp_entry_count))
    else $error("stalled result changed");
  // A hit never coincides with an eviction.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(rsp_hit && rsp_evicted))
    else $error("hit and eviction together");
  // A hit returns a non-null handle.
  a_hnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_hit |-> rsp_handle_out != 32'd0)
    else $error("hit with null handle");
  // Count never exceeds 16 (the default depth).
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_entry_count <= 5'd16)
    else $error("entry count too large");
endmodule

bind lru_resource_cache lrc_checker u_chk (
  .clk_i, .rst_ni,
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
  .rsp_handle_out(rsp.handle_out), .rsp_evicted(rsp.evicted),
  .rsp_evicted_key(rsp.evicted_key), .rsp_entry_count(rsp.entry_count)
);
